// File: sv/word_run_delta_decoder_macros.svh
// Assertion macros for the word run/delta decoder.
`ifndef WORD_RUN_DELTA_DECODER_MACROS_SVH
`define WORD_RUN_DELTA_DECODER_MACROS_SVH

`ifndef NO_ASSERTIONS
// Same-cycle implication, sampled on clk, off while arst_n is low
`define WRDD_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);
// Next-cycle implication, sampled on clk, off while arst_n is low
`define WRDD_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define WRDD_ASSERT_IMP(lbl, ante, cons, msg)
`define WRDD_ASSERT_NXT(lbl, ante, cons, msg)
`endif

`endif

// File: sv/wrdd_pkg.sv
// Types and constants shared by the word run/delta decoder.
package wrdd_pkg;

	// Fixed width of coordinate and pattern fields on the ports
	localparam int FIELD_W = 16;

	// Configuration register indexes
	localparam int CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] CFG_X_ORIGIN   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_Y_ORIGIN   = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_AREA_WIDTH = 2'd2;

	// Result kinds
	localparam logic [1:0] KIND_LIT  = 2'd0;
	localparam logic [1:0] KIND_FILL = 2'd1;
	localparam logic [1:0] KIND_DOT  = 2'd2;
	localparam logic [1:0] KIND_DONE = 2'd3;

	// Parser phases
	typedef enum logic [3:0] {
		PH_LC_LO   = 4'd0,
		PH_LC_HI   = 4'd1,
		PH_OP_LO   = 4'd2,
		PH_OP_HI   = 4'd3,
		PH_SKIP    = 4'd4,
		PH_COUNT   = 4'd5,
		PH_FILL_LO = 4'd6,
		PH_FILL_HI = 4'd7,
		PH_LIT     = 4'd8,
		PH_PEND    = 4'd9
	} phase_t;

	// Input item
	typedef struct packed {
		logic [7:0] stream_byte;
		logic       frame_start;
	} byte_item_t;

	// Result item
	typedef struct packed {
		logic [1:0]         op_kind;
		logic [FIELD_W-1:0] x_pos;
		logic [FIELD_W-1:0] y_pos;
		logic [7:0]         run_pixels;
		logic [FIELD_W-1:0] pixel_pattern;
	} cmd_item_t;

endpackage

// File: sv/word_run_delta_decoder.sv
// Word run/delta frame decoder: one stream byte in, at most one write command out.
//
//  channel   | dir | handshake                 | payload
//  ----------+-----+---------------------------+-------------------------------
//  byte      | in  | byte_valid / byte_ready   | byte_data  (stream_byte, frame_start)
//  cmd       | out | cmd_valid / cmd_ready     | cmd_data   (op_kind, x_pos, y_pos, ...)
//  cfg       | in  | cfg_we                    | cfg_index, cfg_wdata
//
// One byte per cycle sustained while the cmd channel does not stall; a byte's transfer loads the
// input register, then one parser pass feeds its command to the output register.
// The parser state updates in that single pass, so consecutive bytes never wait on it.
// arst_n clears the parser to waiting for a line count and loads the register defaults.
// A stalled cmd channel holds the parser and the input register; byte_ready drops only
// when both are full.
module word_run_delta_decoder
	import wrdd_pkg::*;
#(
	parameter int COORD_BITS = 16
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  byte_valid,
	output logic                  byte_ready,
	input  byte_item_t            byte_data,
	output logic                  cmd_valid,
	input  logic                  cmd_ready,
	output cmd_item_t             cmd_data,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [FIELD_W-1:0]    cfg_wdata
);

`include "word_run_delta_decoder_macros.svh"

	// Configuration registers
	logic [FIELD_W-1:0] x_origin_q, y_origin_q, area_width_q;

	// Input register
	logic       byte_v_s1;
	byte_item_t byte_s1;

	// Parser state
	phase_t                phase_q, phase_n;
	logic [15:0]           lines_q, lines_n;
	logic [15:0]           packets_q, packets_n;
	logic [COORD_BITS-1:0] cur_x_q, cur_x_n;
	logic [COORD_BITS-1:0] cur_y_q, cur_y_n;
	logic [7:0]            held_q, held_n;
	logic [7:0]            lit_q, lit_n;
	logic [6:0]            fill_q, fill_n;

	// Result register
	logic      cmd_valid_q;
	cmd_item_t cmd_q;

	logic      proc_fire;
	logic      res_v;
	cmd_item_t res;

	assign proc_fire  = byte_v_s1 && (!cmd_valid_q || cmd_ready);
	assign byte_ready = !byte_v_s1 || proc_fire;
	assign cmd_valid  = cmd_valid_q;
	assign cmd_data   = cmd_q;

	// Configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			x_origin_q   <= '0;
			y_origin_q   <= '0;
			area_width_q <= 16'd320;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_X_ORIGIN:   x_origin_q   <= cfg_wdata;
				CFG_Y_ORIGIN:   y_origin_q   <= cfg_wdata;
				CFG_AREA_WIDTH: area_width_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_v_s1 <= 1'b0;
		end else if (byte_valid && byte_ready) begin
			byte_v_s1 <= 1'b1;
		end else if (proc_fire) begin
			byte_v_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (byte_valid && byte_ready) begin
			byte_s1 <= byte_data;
		end
	end

	// Parser: next state and result for the byte in the input register
	always_comb begin
		logic [7:0]            b;
		logic [15:0]           w;
		logic [8:0]            fill_pix;
		logic                  pkt_end;
		logic                  line_end;
		logic [COORD_BITS-1:0] x_last;

		b        = byte_s1.stream_byte;
		w        = {b, held_q};
		fill_pix = {(fill_q == 7'd0), fill_q, 1'b0};
		x_last   = COORD_BITS'(x_origin_q + area_width_q - 16'd1);
		pkt_end  = 1'b0;
		line_end = 1'b0;

		phase_n   = phase_q;
		lines_n   = lines_q;
		packets_n = packets_q;
		cur_x_n   = cur_x_q;
		cur_y_n   = cur_y_q;
		held_n    = held_q;
		lit_n     = lit_q;
		fill_n    = fill_q;

		res_v = 1'b0;
		res   = '0;

		// Held frame-done from a line that ended on a write
		if (phase_q == PH_PEND) begin
			res_v         = 1'b1;
			res.op_kind   = KIND_DONE;
		end

		if (byte_s1.frame_start || phase_q == PH_PEND) begin
			held_n  = b;
			phase_n = PH_LC_HI;
		end else begin
			unique case (phase_q)
				PH_LC_HI: begin
					lines_n = w;
					cur_y_n = COORD_BITS'(y_origin_q);
					if (w == 16'd0) begin
						res_v       = 1'b1;
						res.op_kind = KIND_DONE;
						phase_n     = PH_LC_LO;
					end else begin
						phase_n = PH_OP_LO;
					end
				end
				PH_OP_LO: begin
					held_n  = b;
					phase_n = PH_OP_HI;
				end
				PH_OP_HI: begin
					if (w[15:14] == 2'b11) begin
						// line skip: negative word moves down
						cur_y_n = cur_y_q - w[COORD_BITS-1:0];
						phase_n = PH_OP_LO;
					end else if (w[15]) begin
						// dot at the last column
						res_v             = 1'b1;
						res.op_kind       = KIND_DOT;
						res.x_pos         = FIELD_W'(x_last);
						res.y_pos         = FIELD_W'(cur_y_q);
						res.run_pixels    = 8'd1;
						res.pixel_pattern = {8'd0, w[7:0]};
						phase_n           = PH_OP_LO;
					end else begin
						packets_n = w;
						cur_x_n   = COORD_BITS'(x_origin_q);
						if (w == 16'd0) begin
							line_end = 1'b1;
						end else begin
							phase_n = PH_SKIP;
						end
					end
				end
				PH_SKIP: begin
					cur_x_n = cur_x_q + COORD_BITS'(b);
					phase_n = PH_COUNT;
				end
				PH_COUNT: begin
					if (b[7]) begin
						fill_n  = 7'(8'd0 - b);
						phase_n = PH_FILL_LO;
					end else begin
						lit_n = {b[6:0], 1'b0};
						if (b[6:0] == 7'd0) begin
							pkt_end = 1'b1;
						end else begin
							phase_n = PH_LIT;
						end
					end
				end
				PH_FILL_LO: begin
					held_n  = b;
					phase_n = PH_FILL_HI;
				end
				PH_FILL_HI: begin
					res_v             = 1'b1;
					res.op_kind       = KIND_FILL;
					res.x_pos         = FIELD_W'(cur_x_q);
					res.y_pos         = FIELD_W'(cur_y_q);
					res.run_pixels    = fill_pix[7:0];
					res.pixel_pattern = w;
					cur_x_n           = cur_x_q + COORD_BITS'(fill_pix);
					pkt_end           = 1'b1;
				end
				PH_LIT: begin
					res_v             = 1'b1;
					res.op_kind       = KIND_LIT;
					res.x_pos         = FIELD_W'(cur_x_q);
					res.y_pos         = FIELD_W'(cur_y_q);
					res.run_pixels    = 8'd1;
					res.pixel_pattern = {8'd0, b};
					cur_x_n           = cur_x_q + COORD_BITS'(1);
					lit_n             = lit_q - 8'd1;
					if (lit_n == 8'd0) begin
						pkt_end = 1'b1;
					end
				end
				default: begin
					// waiting for line count low, and unused codes
					held_n  = b;
					phase_n = PH_LC_HI;
				end
			endcase

			// End of a packet
			if (pkt_end) begin
				packets_n = packets_q - 16'd1;
				if (packets_n == 16'd0) begin
					line_end = 1'b1;
				end else begin
					phase_n = PH_SKIP;
				end
			end

			// End of a line; frame done waits a byte if this one already wrote
			if (line_end) begin
				cur_y_n = cur_y_q + COORD_BITS'(1);
				lines_n = lines_q - 16'd1;
				if (lines_n != 16'd0) begin
					phase_n = PH_OP_LO;
				end else if (res_v) begin
					phase_n = PH_PEND;
				end else begin
					res_v       = 1'b1;
					res.op_kind = KIND_DONE;
					phase_n     = PH_LC_LO;
				end
			end
		end
	end

	// Parser state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_LC_LO;
			lines_q   <= '0;
			packets_q <= '0;
			cur_x_q   <= '0;
			cur_y_q   <= '0;
			held_q    <= '0;
			lit_q     <= '0;
			fill_q    <= '0;
		end else if (proc_fire) begin
			phase_q   <= phase_n;
			lines_q   <= lines_n;
			packets_q <= packets_n;
			cur_x_q   <= cur_x_n;
			cur_y_q   <= cur_y_n;
			held_q    <= held_n;
			lit_q     <= lit_n;
			fill_q    <= fill_n;
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cmd_valid_q <= 1'b0;
		end else if (proc_fire && res_v) begin
			cmd_valid_q <= 1'b1;
		end else if (cmd_ready) begin
			cmd_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (proc_fire && res_v) begin
			cmd_q <= res;
		end
	end

	// Checks
	`WRDD_ASSERT_IMP(a_stall_blocks_input, byte_v_s1 && cmd_valid_q && !cmd_ready, !byte_ready, "input taken while parser stalled")
	`WRDD_ASSERT_NXT(a_pend_gives_done, proc_fire && phase_q == PH_PEND, cmd_valid_q && cmd_q.op_kind == KIND_DONE, "held frame done not issued")
	`WRDD_ASSERT_IMP(a_done_fields_zero, cmd_valid_q && cmd_q.op_kind == KIND_DONE, cmd_q.x_pos == '0 && cmd_q.y_pos == '0 && cmd_q.run_pixels == '0 && cmd_q.pixel_pattern == '0, "frame done carries nonzero fields")

endmodule

// File: dv/word_run_delta_decoder_checker.sv
// Watches the decoder's channels, predicts each write command and compares it with the DUT.
module word_run_delta_decoder_checker
	import wrdd_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 byte_valid,
	input  logic                 byte_ready,
	input  byte_item_t           byte_data,
	input  logic                 cmd_valid,
	input  logic                 cmd_ready,
	input  cmd_item_t            cmd_data,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [FIELD_W-1:0]   cfg_wdata,
	output int unsigned          fail_count,
	output int unsigned          pending
);

	// Register copies
	logic [15:0] x_org, y_org, area_w;

	// Parser copy
	phase_t      parse_ph;
	logic [15:0] lines_left, packets_left, col, row;
	logic [7:0]  held_lo, lit_left;
	logic [6:0]  fill_words;

	// Write commands still owed by the DUT, oldest first
	cmd_item_t   pending_writes[$];

	function automatic cmd_item_t make_cmd(input logic [1:0] kind, input logic [15:0] x,
			input logic [15:0] y, input logic [7:0] run, input logic [15:0] pat);
		cmd_item_t c;
		c.op_kind       = kind;
		c.x_pos         = x;
		c.y_pos         = y;
		c.run_pixels    = run;
		c.pixel_pattern = pat;
		return c;
	endfunction

	// Line end: step down one row; the last line closes the frame.
	// A frame that closes on a write holds its frame done for the next byte.
	task automatic close_line(inout bit have, inout cmd_item_t c);
		row        = row + 16'd1;
		lines_left = lines_left - 16'd1;
		if (lines_left == 16'd0) begin
			if (have) begin
				parse_ph = PH_PEND;
			end else begin
				c        = make_cmd(KIND_DONE, '0, '0, '0, '0);
				have     = 1'b1;
				parse_ph = PH_LC_LO;
			end
		end else begin
			parse_ph = PH_OP_LO;
		end
	endtask

	task automatic close_packet(inout bit have, inout cmd_item_t c);
		packets_left = packets_left - 16'd1;
		if (packets_left == 16'd0) begin
			close_line(have, c);
		end else begin
			parse_ph = PH_SKIP;
		end
	endtask

	// One stream byte through the parser; queues the write it causes, if any
	task automatic parse_stream_byte(input logic [7:0] b, input logic fs);
		cmd_item_t   c;
		bit          have;
		logic [15:0] w;
		logic [15:0] span;
		logic [7:0]  neg;
		have = 1'b0;
		c    = '0;
		if (parse_ph == PH_PEND) begin
			c    = make_cmd(KIND_DONE, '0, '0, '0, '0);
			have = 1'b1;
		end
		if (fs || parse_ph == PH_PEND || parse_ph == PH_LC_LO) begin
			held_lo  = b;
			parse_ph = PH_LC_HI;
		end else begin
			case (parse_ph)
				PH_LC_HI: begin
					lines_left = {b, held_lo};
					row        = y_org;
					if (lines_left == 16'd0) begin
						c        = make_cmd(KIND_DONE, '0, '0, '0, '0);
						have     = 1'b1;
						parse_ph = PH_LC_LO;
					end else begin
						parse_ph = PH_OP_LO;
					end
				end
				PH_OP_LO: begin
					held_lo  = b;
					parse_ph = PH_OP_HI;
				end
				PH_OP_HI: begin
					w = {b, held_lo};
					if (w[15:14] == 2'b11) begin
						// line skip: subtracting a negative word moves down
						row      = row - w;
						parse_ph = PH_OP_LO;
					end else if (w[15]) begin
						c = make_cmd(KIND_DOT, x_org + area_w - 16'd1, row, 8'd1,
							{8'h00, w[7:0]});
						have     = 1'b1;
						parse_ph = PH_OP_LO;
					end else begin
						packets_left = w;
						col          = x_org;
						if (w == 16'd0) begin
							close_line(have, c);
						end else begin
							parse_ph = PH_SKIP;
						end
					end
				end
				PH_SKIP: begin
					col      = col + {8'h00, b};
					parse_ph = PH_COUNT;
				end
				PH_COUNT: begin
					if (b[7]) begin
						neg        = 8'h00 - b;
						fill_words = neg[6:0];
						parse_ph   = PH_FILL_LO;
					end else begin
						lit_left = {b[6:0], 1'b0};
						if (lit_left == 8'd0) begin
							close_packet(have, c);
						end else begin
							parse_ph = PH_LIT;
						end
					end
				end
				PH_FILL_LO: begin
					held_lo  = b;
					parse_ph = PH_FILL_HI;
				end
				PH_FILL_HI: begin
					// zero words stands for 128, i.e. 256 pixels reported as 0
					span = (fill_words == 7'd0) ? 16'd256 : {8'h00, fill_words, 1'b0};
					c    = make_cmd(KIND_FILL, col, row, span[7:0], {b, held_lo});
					have = 1'b1;
					col  = col + span;
					close_packet(have, c);
				end
				PH_LIT: begin
					c        = make_cmd(KIND_LIT, col, row, 8'd1, {8'h00, b});
					have     = 1'b1;
					col      = col + 16'd1;
					lit_left = lit_left - 8'd1;
					if (lit_left == 8'd0) begin
						close_packet(have, c);
					end
				end
				default: begin
					held_lo  = b;
					parse_ph = PH_LC_HI;
				end
			endcase
		end
		if (have) begin
			pending_writes.push_back(c);
		end
	endtask

	task automatic check_field(input string name, input int unsigned want_v,
			input int unsigned got_v);
		if (want_v != got_v) begin
			$error("%s: expected 0x%0h, actual 0x%0h", name, want_v, got_v);
			fail_count++;
		end
	endtask

	// Register writes, command transfers, then byte transfers
	always @(posedge clk or negedge arst_n) begin
		cmd_item_t want;
		if (!arst_n) begin
			x_org        = 16'd0;
			y_org        = 16'd0;
			area_w       = 16'd320;
			parse_ph     = PH_LC_LO;
			lines_left   = '0;
			packets_left = '0;
			col          = '0;
			row          = '0;
			held_lo      = '0;
			lit_left     = '0;
			fill_words   = '0;
			pending_writes.delete();
			fail_count   = 0;
			pending      = 0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					CFG_X_ORIGIN:   x_org  = cfg_wdata;
					CFG_Y_ORIGIN:   y_org  = cfg_wdata;
					CFG_AREA_WIDTH: area_w = cfg_wdata;
					default: ;
				endcase
			end
			if (cmd_valid && cmd_ready) begin
				if (pending_writes.size() == 0) begin
					$error("write command with none expected: op_kind %0d x 0x%0h y 0x%0h",
						cmd_data.op_kind, cmd_data.x_pos, cmd_data.y_pos);
					fail_count++;
				end else begin
					want = pending_writes.pop_front();
					check_field("op_kind", want.op_kind, cmd_data.op_kind);
					check_field("x_pos", want.x_pos, cmd_data.x_pos);
					check_field("y_pos", want.y_pos, cmd_data.y_pos);
					check_field("run_pixels", want.run_pixels, cmd_data.run_pixels);
					check_field("pixel_pattern", want.pixel_pattern, cmd_data.pixel_pattern);
				end
			end
			if (byte_valid && byte_ready) begin
				parse_stream_byte(byte_data.stream_byte, byte_data.frame_start);
			end
			pending = pending_writes.size();
		end
	end

endmodule

// File: dv/word_run_delta_decoder_tb.sv
// Top of the decoder testbench: clock, reset, frame stimulus, command back-pressure, verdict.
module word_run_delta_decoder_tb
	import wrdd_pkg::*;
;

	localparam int unsigned STREAM_BYTES = 1850;

	logic                 clk;
	logic                 arst_n;
	logic                 byte_valid;
	logic                 byte_ready;
	byte_item_t           byte_data;
	logic                 cmd_valid;
	logic                 cmd_ready;
	cmd_item_t            cmd_data;
	logic                 cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [FIELD_W-1:0]   cfg_wdata;
	int unsigned          fail_count;
	int unsigned          pending;

	int unsigned          burst_left;
	int unsigned          sent_bytes;
	int unsigned          hold_reqs;

	word_run_delta_decoder dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.byte_valid (byte_valid),
		.byte_ready (byte_ready),
		.byte_data  (byte_data),
		.cmd_valid  (cmd_valid),
		.cmd_ready  (cmd_ready),
		.cmd_data   (cmd_data),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_wdata  (cfg_wdata)
	);

	word_run_delta_decoder_checker cmd_check (
		.clk        (clk),
		.arst_n     (arst_n),
		.byte_valid (byte_valid),
		.byte_ready (byte_ready),
		.byte_data  (byte_data),
		.cmd_valid  (cmd_valid),
		.cmd_ready  (cmd_ready),
		.cmd_data   (cmd_data),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_wdata  (cfg_wdata),
		.fail_count (fail_count),
		.pending    (pending)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// One byte transfer; bursts of random length separated by random gaps
	task automatic send_byte(input logic [7:0] b, input logic fs);
		int unsigned gap;
		@(negedge clk);
		if (burst_left == 0) begin
			gap        = $urandom_range(1, 6);
			burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 160)
				: $urandom_range(1, 16);
			byte_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		byte_valid                <= 1'b1;
		byte_data.stream_byte     <= b;
		byte_data.frame_start     <= fs;
		burst_left--;
		sent_bytes++;
		do @(posedge clk); while (!byte_ready);
	endtask

	// Little-endian stream word
	task automatic send_word(input logic [15:0] w);
		send_byte(w[7:0], 1'b0);
		send_byte(w[15:8], 1'b0);
	endtask

	// Drop valid, let every owed command drain, then allow for bytes still in the pipe
	task automatic settle();
		@(negedge clk);
		byte_valid <= 1'b0;
		while (pending != 0) @(negedge clk);
		repeat (8) @(negedge clk);
	endtask

	task automatic write_area(input logic [15:0] x, input logic [15:0] y,
			input logic [15:0] w);
		cfg_we    <= 1'b1;
		cfg_index <= CFG_X_ORIGIN;
		cfg_wdata <= x;
		@(negedge clk);
		cfg_index <= CFG_Y_ORIGIN;
		cfg_wdata <= y;
		@(negedge clk);
		cfg_index <= CFG_AREA_WIDTH;
		cfg_wdata <= w;
		@(negedge clk);
		cfg_we    <= 1'b0;
	endtask

	// Well-formed frame with random content; a truncated one claims a random line count or more lines than it sends
	task automatic send_frame(input logic fs, input bit truncate);
		logic [15:0] lc;
		logic [7:0]  cnt;
		int unsigned n_lines;
		int unsigned n_pk;
		n_lines = ($urandom_range(0, 11) == 0) ? 0 : $urandom_range(1, 4);
		lc      = 16'(n_lines);
		if (truncate) begin
			lc = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'(n_lines + $urandom_range(1, 3));
		end
		send_byte(lc[7:0], fs);
		send_byte(lc[15:8], 1'b0);
		repeat (n_lines) begin
			// line skips and last-column dots ahead of the packet count
			repeat ($urandom_range(0, 2)) begin
				send_word({($urandom_range(0, 1) != 0) ? 2'b11 : 2'b10, 14'($urandom)});
			end
			n_pk = ($urandom_range(0, 7) == 0) ? 0 : $urandom_range(1, 3);
			send_word(16'(n_pk));
			repeat (n_pk) begin
				send_byte(8'($urandom), 1'b0);
				if ($urandom_range(0, 1) != 0) begin
					cnt = ($urandom_range(0, 9) == 0) ? 8'h80 : 8'($urandom_range(128, 255));
					send_byte(cnt, 1'b0);
					send_word(16'($urandom));
				end else begin
					cnt = ($urandom_range(0, 24) == 0) ? 8'($urandom_range(5, 127))
						: 8'($urandom_range(0, 4));
					send_byte(cnt, 1'b0);
					repeat (2 * cnt) send_byte(8'($urandom), 1'b0);
				end
			end
		end
	endtask

	// Stimulus and verdict
	initial begin
		int unsigned pick;
		bit          need_fs;
		byte_valid = 1'b0;
		byte_data  = '0;
		cfg_we     = 1'b0;
		cfg_index  = CFG_X_ORIGIN;
		cfg_wdata  = '0;
		arst_n     = 1'b0;
		burst_left = 0;
		sent_bytes = 0;
		hold_reqs  = 0;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		settle();
		write_area(16'h0010, 16'h0020, 16'd320);

		// zero line count: frame done at once
		send_byte(8'h00, 1'b1);
		send_byte(8'h00, 1'b0);
		// one line, opened without frame_start right after frame done
		send_word(16'h0001);
		send_word(16'hfffe);    // line skip, moves down two
		send_word(16'h807f);    // last-column dot
		send_word(16'h0002);    // two packets
		send_byte(8'hff, 1'b0); // widest column skip
		send_byte(8'h80, 1'b0); // fill of 128 words
		send_word(16'h1234);
		send_byte(8'h00, 1'b0);
		send_byte(8'h01, 1'b0); // one literal pair, ends the frame on a write
		send_byte(8'hff, 1'b0);
		send_byte(8'h00, 1'b0);
		// frame_start byte releases the held frame done and opens a new frame
		send_byte(8'h02, 1'b1);
		send_byte(8'h00, 1'b0);
		send_word(16'h0001);
		send_byte(8'h05, 1'b0);
		send_byte(8'h00, 1'b0); // literal count zero, line ends with one left
		need_fs = 1'b1;

		for (int ph = 0; ph < 6; ph++) begin
			settle();
			case (ph)
				0: write_area(16'h0000, 16'h0000, 16'h0001);
				1: write_area(16'hffff, 16'hffff, 16'hffff);
				3: write_area(16'h0000, 16'h0000, 16'd320);
				4: write_area(16'h8000, 16'hfff0, 16'h0002);
				default: write_area(16'($urandom), 16'($urandom), 16'($urandom_range(1, 65535)));
			endcase
			// long receiver hold-off while bytes keep coming
			if (ph == 1 || ph == 4) begin
				hold_reqs++;
			end
			while (sent_bytes < 24 + (ph + 1) * STREAM_BYTES / 6) begin
				pick = $urandom_range(0, 19);
				if (pick < 2) begin
					repeat ($urandom_range(1, 24)) begin
						send_byte(8'($urandom), ($urandom_range(0, 15) == 0));
					end
					need_fs = 1'b1;
				end else if (pick < 4) begin
					send_frame(1'b1, 1'b1);
					need_fs = 1'b1;
				end else begin
					send_frame(need_fs || ($urandom_range(0, 3) != 0), 1'b0);
					need_fs = 1'b0;
				end
			end
		end

		settle();
		repeat (8) @(negedge clk);
		if (fail_count == 0 && pending == 0) begin
			$display("word_run_delta_decoder: match");
		end else begin
			$display("word_run_delta_decoder: mismatch");
		end
		$finish;
	end

	// Command back-pressure: a pattern that changes mode now and then, plus long hold-offs
	initial begin
		int unsigned mode;
		int unsigned mode_left;
		int unsigned holds_done;
		logic [31:0] rcv_cycle;
		cmd_ready  = 1'b0;
		mode       = 0;
		mode_left  = 0;
		holds_done = 0;
		rcv_cycle  = '0;
		forever begin
			@(negedge clk);
			if (hold_reqs != holds_done) begin
				holds_done++;
				cmd_ready <= 1'b0;
				repeat (400) @(negedge clk);
			end
			if (mode_left == 0) begin
				mode      = $urandom_range(0, 3);
				mode_left = $urandom_range(20, 200);
			end
			mode_left--;
			case (mode)
				0: cmd_ready <= 1'b1;
				1: cmd_ready <= ($urandom_range(0, 3) != 0);
				2: cmd_ready <= ($urandom_range(0, 3) == 0);
				default: cmd_ready <= (rcv_cycle[1:0] != 2'b00);
			endcase
			rcv_cycle = rcv_cycle + 32'd1;
		end
	end

	// Watchdog
	initial begin
		#6_000_000;
		$display("word_run_delta_decoder: mismatch");
		$finish;
	end

endmodule
